[src/rrtt_pkg.sv]
// shared types and constants of the round-robin thread table
`timescale 1ns / 1ps

package rrtt_pkg;

  // default table size and fixed field widths
  localparam int SLOTS_DEF = 16;
  localparam int TID_W     = 8;
  localparam int PICK_W    = 4;

  // event kinds
  typedef enum logic [1:0] {
    FN_CREATE = 2'd0,
    FN_YIELD  = 2'd1,
    FN_EXIT   = 2'd2,
    FN_JOIN   = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // one registered event
  typedef struct packed {
    func_e            func;
    logic [TID_W-1:0] target_tid;
  } req_t;

  // one result
  typedef struct packed {
    status_e           status;
    logic [TID_W-1:0]  issued_tid;
    logic              switched;
    logic [PICK_W-1:0] picked_slot;
    logic [TID_W-1:0]  running_tid;
    logic              target_exited;
  } rsp_t;

endpackage

[src/rrtt_in_if.sv]
// event channel interface
`timescale 1ns / 1ps

interface rrtt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] target_tid;

  modport source (output valid, output func, output target_tid, input ready);
  modport sink   (input valid, input func, input target_tid, output ready);
endinterface

[src/rrtt_out_if.sv]
// result channel interface
`timescale 1ns / 1ps

interface rrtt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] issued_tid;
  logic       switched;
  logic [3:0] picked_slot;
  logic [7:0] running_tid;
  logic       target_exited;

  modport source (output valid, output status, output issued_tid, output switched,
                  output picked_slot, output running_tid, output target_exited,
                  input ready);
  modport sink   (input valid, input status, input issued_tid, input switched,
                  input picked_slot, input running_tid, input target_exited,
                  output ready);
endinterface

[src/rrtt_in_reg.sv]
// input register stage for event transactions
`timescale 1ns / 1ps

module rrtt_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rrtt_pkg::req_t in_req_i,
  output logic          req_valid_o,
  input  logic          req_ready_i,
  output rrtt_pkg::req_t req_o
);

  logic           valid_q;
  rrtt_pkg::req_t req_q;

  // take a new transaction when empty or when the held one moves on
  assign in_ready_o  = !valid_q || req_ready_i;
  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
  end

endmodule

[src/rrtt_picker.sv]
// round-robin picker: rotate the runnable mask and find the first set slot
`timescale 1ns / 1ps

module rrtt_picker #(
  parameter int SLOTS = rrtt_pkg::SLOTS_DEF
) (
  input  logic [SLOTS-1:0]         runnable_i,
  input  logic [$clog2(SLOTS)-1:0] start_i,
  output logic                     found_o,
  output logic [$clog2(SLOTS)-1:0] slot_o
);

  localparam int IDX_W = $clog2(SLOTS);

  logic [2*SLOTS-1:0] doubled;
  logic [2*SLOTS-1:0] shifted;
  logic [SLOTS-1:0]   rot;
  logic [IDX_W:0]     shamt;
  logic [IDX_W-1:0]   k_idx;
  logic [IDX_W:0]     sum;

  // rot[k] is the slot k+1 places after start, wrapping round
  assign doubled = {runnable_i, runnable_i};
  assign shamt   = {1'b0, start_i} + (IDX_W+1)'(1);
  assign shifted = doubled >> shamt;
  assign rot     = shifted[SLOTS-1:0];

  // lowest set offset, the start slot itself comes last
  always_comb begin
    found_o = 1'b0;
    k_idx   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (rot[k]) begin
        found_o = 1'b1;
        k_idx   = IDX_W'(k);
      end
    end
  end

  // back to a slot index, sum stays below twice the table size
  always_comb begin
    sum = shamt + {1'b0, k_idx};
    if (sum >= (IDX_W+1)'(SLOTS)) begin
      sum = sum - (IDX_W+1)'(SLOTS);
    end
    slot_o = sum[IDX_W-1:0];
  end

endmodule

[src/rrtt_core.sv]
// thread table state, event processing and result register
`timescale 1ns / 1ps

module rrtt_core #(
  parameter int SLOTS = rrtt_pkg::SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  rrtt_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output rrtt_pkg::rsp_t rsp_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int TID_W = rrtt_pkg::TID_W;

  // table state
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [SLOTS-1:0] exited_q, exited_d;
  logic [TID_W-1:0] tid_q [SLOTS];
  logic [IDX_W-1:0] cur_slot_q, cur_slot_d;
  logic             cur_valid_q, cur_valid_d;
  logic [TID_W-1:0] next_id_q, next_id_d;

  // result register
  logic             rsp_valid_q;
  rrtt_pkg::rsp_t   rsp_q, rsp_d;

  logic             fire;
  logic             is_create, is_yield, is_exit, is_join;
  logic [SLOTS-1:0] exited_n;
  logic [SLOTS-1:0] runnable;
  logic [IDX_W-1:0] start;
  logic             pick_found;
  logic [IDX_W-1:0] pick_slot;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             hit_found;
  logic             hit_exited;
  logic [IDX_W+3:0] cur_ext;

  // handshake: process when the result register can take the outcome
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign fire        = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign is_create = (req_i.func == rrtt_pkg::FN_CREATE);
  assign is_yield  = (req_i.func == rrtt_pkg::FN_YIELD);
  assign is_exit   = (req_i.func == rrtt_pkg::FN_EXIT);
  assign is_join   = (req_i.func == rrtt_pkg::FN_JOIN);

  // exited marks after the yield or exit touches the current slot
  always_comb begin
    exited_n = exited_q;
    if (cur_valid_q && is_yield) begin
      exited_n[cur_slot_q] = 1'b0;
    end else if (cur_valid_q && is_exit) begin
      exited_n[cur_slot_q] = 1'b1;
    end
  end

  assign runnable = valid_q & ~exited_n;
  assign start    = cur_valid_q ? cur_slot_q : '0;

  rrtt_picker #(
    .SLOTS (SLOTS)
  ) u_picker (
    .runnable_i (runnable),
    .start_i    (start),
    .found_o    (pick_found),
    .slot_o     (pick_slot)
  );

  // lowest free slot for create
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(s);
      end
    end
  end

  // lowest valid slot holding the joined id
  always_comb begin
    hit_found  = 1'b0;
    hit_exited = 1'b0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (valid_q[s] && (tid_q[s] == req_i.target_tid)) begin
        hit_found  = 1'b1;
        hit_exited = exited_q[s];
      end
    end
  end

  // next state
  always_comb begin
    valid_d     = valid_q;
    exited_d    = exited_q;
    cur_slot_d  = cur_slot_q;
    cur_valid_d = cur_valid_q;
    next_id_d   = next_id_q;
    case (req_i.func)
      rrtt_pkg::FN_CREATE: begin
        next_id_d = next_id_q + TID_W'(1);
        if (free_found) begin
          valid_d[free_idx]  = 1'b1;
          exited_d[free_idx] = 1'b0;
        end
      end
      rrtt_pkg::FN_YIELD, rrtt_pkg::FN_EXIT: begin
        exited_d = exited_n;
        if (pick_found) begin
          cur_slot_d  = pick_slot;
          cur_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result fields
  assign cur_ext = {4'b0000, cur_slot_d};

  always_comb begin
    rsp_d               = '0;
    rsp_d.status        = rrtt_pkg::ST_OK;
    rsp_d.issued_tid    = is_create ? next_id_q : '0;
    rsp_d.switched      = (is_yield || is_exit) && pick_found;
    rsp_d.picked_slot   = cur_ext[3:0];
    rsp_d.running_tid   = cur_valid_d ? tid_q[cur_slot_d] : '0;
    rsp_d.target_exited = is_join && hit_found && hit_exited;
    if (is_create && !free_found) begin
      rsp_d.status = rrtt_pkg::ST_FULL;
    end else if (is_join && !hit_found) begin
      rsp_d.status = rrtt_pkg::ST_NOT_FOUND;
    end
  end

  // control state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      exited_q    <= '0;
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      next_id_q   <= TID_W'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        valid_q     <= valid_d;
        exited_q    <= exited_d;
        cur_slot_q  <= cur_slot_d;
        cur_valid_q <= cur_valid_d;
        next_id_q   <= next_id_d;
      end
      if (req_ready_o) begin
        rsp_valid_q <= req_valid_i;
      end
    end
  end

  // thread ids and result payload
  always_ff @(posedge clk_i) begin
    if (fire && is_create && free_found) begin
      tid_q[free_idx] <= next_id_q;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

`ifndef SYNTHESIS
  // the current slot always holds a valid thread
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> valid_q[cur_slot_q])
    else $error("current slot is not valid");

  // a successful pick leaves a current thread behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && rsp_d.switched |=> cur_valid_q)
    else $error("switch without current thread");

  // every create consumes exactly one id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_create |=> next_id_q == $past(next_id_q) + TID_W'(1))
    else $error("id counter did not advance on create");

  // a successful create adds exactly one slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_create && free_found |=>
      $countones(valid_q) == $countones($past(valid_q)) + 1)
    else $error("create did not fill one slot");

  // full is reported only with every slot taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (rsp_d.status == rrtt_pkg::ST_FULL) |-> (&valid_q))
    else $error("full reported with a free slot");
`endif

endmodule

[src/round_robin_thread_table_top.sv]
// top level of the round-robin thread table
//
//   channel   dir   payload                                   transfer
//   in_i      in    func, target_tid                          valid && ready
//   out_o     out   status, issued_tid, switched,             valid && ready
//                   picked_slot, running_tid, target_exited
//
// One event is accepted per cycle while out_o is not stalled; an accepted event
// passes the input register, then the table update and result register, before
// its result is offered. Table state and result register update together.
// Reset clears all slot marks, the current thread and sets the next id to 1.
// A stalled result holds the result register; the input register keeps one
// further event, after which in_i.ready drops until out_o is drained.
`timescale 1ns / 1ps

module round_robin_thread_table_top #(
  parameter int SLOTS = rrtt_pkg::SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrtt_in_if.sink    in_i,
  rrtt_out_if.source out_o
);

  rrtt_pkg::req_t in_req;
  rrtt_pkg::req_t req;
  logic           req_valid;
  logic           req_ready;
  rrtt_pkg::rsp_t rsp;

  // unpack the event transaction
  assign in_req.func       = rrtt_pkg::func_e'(in_i.func);
  assign in_req.target_tid = in_i.target_tid;

  rrtt_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_req_i    (in_req),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  rrtt_core #(
    .SLOTS (SLOTS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (out_o.valid),
    .rsp_ready_i (out_o.ready),
    .rsp_o       (rsp)
  );

  // pack the result transaction
  assign out_o.status        = rsp.status;
  assign out_o.issued_tid    = rsp.issued_tid;
  assign out_o.switched      = rsp.switched;
  assign out_o.picked_slot   = rsp.picked_slot;
  assign out_o.running_tid   = rsp.running_tid;
  assign out_o.target_exited = rsp.target_exited;

endmodule

[bench/tb_round_robin_thread_table_top.sv]
// self-checking testbench of the round-robin thread table top level
`timescale 1ns / 1ps

module tb_round_robin_thread_table_top;
  import rrtt_pkg::*;

  localparam int TBL_SLOTS   = SLOTS_DEF;
  localparam int N_DIRECTED  = 25;
  localparam int N_EVENTS    = 1450;
  localparam int DRAIN_CYC   = 8;
  localparam int HOLD_CYC    = 60;
  localparam int HOLD_AT     = 200;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i;
  logic rst_ni;

  rrtt_in_if  ev_if ();
  rrtt_out_if res_if ();

  round_robin_thread_table_top #(
    .SLOTS (TBL_SLOTS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ev_if),
    .out_o  (res_if)
  );

  // thread table predictor and result checker
  class thread_table_sb;
    bit             slot_used [TBL_SLOTS];
    bit             slot_done [TBL_SLOTS];
    logic [7:0]     slot_id   [TBL_SLOTS];
    int unsigned    cur_slot;
    bit             cur_live;
    logic [7:0]     id_next;
    rsp_t           pending_results [$];
    int unsigned    errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_done[i] = 1'b0;
        slot_id[i]   = '0;
      end
      cur_slot = 0;
      cur_live = 1'b0;
      id_next  = 8'd1;
      errors   = 0;
    endfunction

    // round-robin search from the slot after the current one, current last
    function bit pick_runnable();
      int unsigned base;
      int unsigned s;
      base = cur_live ? cur_slot : 0;
      for (int i = 1; i <= TBL_SLOTS; i++) begin
        s = (base + i) % TBL_SLOTS;
        if (slot_used[s] && !slot_done[s]) begin
          cur_slot = s;
          cur_live = 1'b1;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // apply one accepted event and queue the result it must produce
    function void note_event(func_e f, logic [7:0] tid);
      rsp_t r;
      r = '0;
      r.status = ST_OK;
      case (f)
        FN_CREATE: begin
          r.issued_tid = id_next;
          r.status     = ST_FULL;
          for (int i = 0; i < TBL_SLOTS; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_done[i] = 1'b0;
              slot_id[i]   = id_next;
              r.status     = ST_OK;
              break;
            end
          end
          id_next = id_next + 8'd1;
        end
        FN_YIELD: begin
          if (cur_live) slot_done[cur_slot] = 1'b0;
          r.switched = pick_runnable();
        end
        FN_EXIT: begin
          if (cur_live) slot_done[cur_slot] = 1'b1;
          r.switched = pick_runnable();
        end
        default: begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < TBL_SLOTS; i++) begin
            if (slot_used[i] && slot_id[i] == tid) begin
              r.status        = ST_OK;
              r.target_exited = slot_done[i];
              break;
            end
          end
        end
      endcase
      r.picked_slot = cur_slot[3:0];
      r.running_tid = cur_live ? slot_id[cur_slot] : 8'd0;
      pending_results.push_back(r);
    endfunction

    task report(string what, int unsigned got, int unsigned exp);
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, exp);
      errors++;
    endtask

    // compare one transaction on the result channel with the oldest prediction
    task check_result(rsp_t got);
      rsp_t exp;
      if (pending_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        exp = pending_results.pop_front();
        if (got.status != exp.status) report("status", got.status, exp.status);
        if (got.issued_tid != exp.issued_tid)
          report("issued_tid", got.issued_tid, exp.issued_tid);
        if (got.switched != exp.switched) report("switched", got.switched, exp.switched);
        if (got.picked_slot != exp.picked_slot)
          report("picked_slot", got.picked_slot, exp.picked_slot);
        if (got.running_tid != exp.running_tid)
          report("running_tid", got.running_tid, exp.running_tid);
        if (got.target_exited != exp.target_exited)
          report("target_exited", got.target_exited, exp.target_exited);
      end
    endtask
  endclass

  thread_table_sb sb = new();

  // directed opening: empty table, lone thread exit and revive, fill, overflow
  func_e      dir_func [N_DIRECTED] = '{
    FN_YIELD, FN_JOIN, FN_CREATE, FN_EXIT, FN_EXIT, FN_JOIN, FN_YIELD,
    FN_CREATE, FN_CREATE, FN_CREATE, FN_CREATE, FN_CREATE, FN_CREATE, FN_CREATE,
    FN_CREATE, FN_CREATE, FN_CREATE, FN_CREATE, FN_CREATE, FN_CREATE, FN_CREATE,
    FN_CREATE, FN_CREATE, FN_YIELD, FN_JOIN
  };
  logic [7:0] dir_tid [N_DIRECTED] = '{
    8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h01, 8'h00,
    8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff,
    8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00,
    8'hff, 8'h00, 8'hff, 8'hff
  };

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // offer one event after an idle gap and wait until it is taken
  task automatic send_event(input func_e f, input logic [7:0] tid, input int unsigned gap);
    if (gap != 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ev_if.valid      <= 1'b1;
    ev_if.func       <= f;
    ev_if.target_tid <= tid;
    do @(posedge clk_i); while (!ev_if.ready);
    sb.note_event(f, tid);
  endtask

  // event stream
  initial begin
    func_e       f;
    logic [7:0]  tid;
    int unsigned gap;
    int unsigned pick;
    rst_ni           = 1'b0;
    ev_if.valid      <= 1'b0;
    ev_if.func       <= FN_CREATE;
    ev_if.target_tid <= 8'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < N_EVENTS; n++) begin
      if (n < N_DIRECTED) begin
        f   = dir_func[n];
        tid = dir_tid[n];
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15)      f = FN_CREATE;
        else if (pick < 50) f = FN_YIELD;
        else if (pick < 80) f = FN_EXIT;
        else                f = FN_JOIN;
        // half of the targets aim near the live ids, the rest anywhere
        if ($urandom_range(0, 1) == 0) tid = 8'($urandom_range(0, 20));
        else                           tid = 8'($urandom_range(0, 255));
      end
      // back-to-back stretches between random gaps
      gap = ((n % 300) < 60) ? 0 : $urandom_range(0, 3);
      send_event(f, tid, gap);
    end
    ev_if.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result sink with random stalls and one long hold-off
  initial begin
    rsp_t        got;
    int unsigned gap;
    int unsigned n_got;
    n_got = 0;
    forever begin
      if (n_got == HOLD_AT)            gap = HOLD_CYC;
      else if ((n_got % 250) < 50)     gap = 0;
      else                             gap = $urandom_range(0, 3);
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got.status        = status_e'(res_if.status);
      got.issued_tid    = res_if.issued_tid;
      got.switched      = res_if.switched;
      got.picked_slot   = res_if.picked_slot;
      got.running_tid   = res_if.running_tid;
      got.target_exited = res_if.target_exited;
      sb.check_result(got);
      n_got++;
    end
  end

  // watchdog
  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
